// ===== hdl/ucsj_pkg.sv =====
// ----------------------------------------------------------------------------
// ucsj_pkg
// shared types, constants and arithmetic helpers of the unicycle step unit
// ----------------------------------------------------------------------------
package ucsj_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [15:0] STEP_TIME_RST = 16'd6554;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP_TIME = 2'd0;
  localparam logic [1:0] CFG_MODEL_SEL = 2'd1;

  // model codes
  localparam logic MODEL_UNICYCLE = 1'b0;
  localparam logic MODEL_ERROR    = 1'b1;

  localparam logic signed [63:0] INV_TWO_PI_Q32 = 64'sd683565276;
  localparam logic signed [63:0] HALF_PI_Q30    = 64'sd1686629713;
  localparam logic [30:0]        Q30_ONE        = 31'h4000_0000;

  // horner divisors and their reciprocals (floor of 2^32 / k)
  localparam logic [6:0]  K_S1 = 7'd72;
  localparam logic [6:0]  K_C1 = 7'd90;
  localparam logic [6:0]  K_S2 = 7'd42;
  localparam logic [6:0]  K_C2 = 7'd56;
  localparam logic [6:0]  K_S3 = 7'd20;
  localparam logic [6:0]  K_C3 = 7'd30;
  localparam logic [6:0]  K_S4 = 7'd6;
  localparam logic [6:0]  K_C4 = 7'd12;
  localparam logic [31:0] M_S1 = 32'((64'd1 << 32) / 72);
  localparam logic [31:0] M_C1 = 32'((64'd1 << 32) / 90);
  localparam logic [31:0] M_S2 = 32'((64'd1 << 32) / 42);
  localparam logic [31:0] M_C2 = 32'((64'd1 << 32) / 56);
  localparam logic [31:0] M_S3 = 32'((64'd1 << 32) / 20);
  localparam logic [31:0] M_C3 = 32'((64'd1 << 32) / 30);
  localparam logic [31:0] M_S4 = 32'((64'd1 << 32) / 6);
  localparam logic [31:0] M_C4 = 32'((64'd1 << 32) / 12);

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    q_t s0;
    q_t s1;
    q_t s2;
    q_t dv;
    q_t dw;
  } side_t;

  typedef struct packed {
    q_t next_value;
    q_t dstate0;
    q_t dstate1;
    q_t dstate2;
    q_t dctrl0;
    q_t dctrl1;
  } row_t;

  // rounded arithmetic shift, ties toward plus infinity
  function automatic logic signed [65:0] rnd_asr(input logic signed [65:0] v,
                                                 input int unsigned sh);
    rnd_asr = (v + (66'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic q_t sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // floor(p / k) for p below 2^30 via reciprocal multiply and one correction
  function automatic logic [29:0] div_k(input logic [29:0] p, input logic [6:0] k,
                                        input logic [31:0] m);
    logic [61:0] pm;
    logic [29:0] q0;
    logic [36:0] qk;
    logic [30:0] rem;
    pm  = 62'(p) * 62'(m);
    q0  = pm[61:32];
    qk  = 37'(q0) * 37'(k);
    rem = 31'(37'(p) - qk);
    div_k = (rem >= 31'(k)) ? q0 + 30'd1 : q0;
  endfunction

endpackage

// ===== hdl/ucsj_front.sv =====
// ----------------------------------------------------------------------------
// ucsj_front
// scales speeds by dt, turns the heading into quadrant and reduced angle
// ----------------------------------------------------------------------------
module ucsj_front #(
  parameter int FRAC_BITS = ucsj_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  ucsj_pkg::q_t            s0,
  input  ucsj_pkg::q_t            s1,
  input  ucsj_pkg::q_t            s2,
  input  ucsj_pkg::q_t            v,
  input  ucsj_pkg::q_t            w,
  input  logic [15:0]             step_time,
  output logic                    out_vld,
  output ucsj_pkg::side_t         side,
  output ucsj_pkg::q_t            x,
  output logic signed [63:0]      xx,
  output logic [1:0]              quad
);

  logic [2:0] vld_r;

  // stage 1
  ucsj_pkg::q_t       a0_r, a1_r, a2_r;
  logic signed [48:0] pv_r, pw_r;
  logic signed [63:0] pth_r;
  // stage 2
  ucsj_pkg::side_t    side2_r;
  logic signed [63:0] xp_r;
  logic [1:0]         quad2_r;
  // stage 3
  ucsj_pkg::side_t    side3_r;
  ucsj_pkg::q_t       x_r;
  logic signed [63:0] xx_r;
  logic [1:0]         quad3_r;

  logic [31:0]        phase;
  logic [31:0]        ph_add;
  logic [1:0]         quad_nxt;
  logic signed [31:0] red;
  ucsj_pkg::q_t       xv;
  logic signed [16:0] dts;

  assign dts      = $signed({1'b0, step_time});
  assign phase    = pth_r[FRAC_BITS+31 -: 32];
  assign ph_add   = phase + 32'h2000_0000;
  assign quad_nxt = ph_add[31:30];
  assign red      = $signed(phase - {quad_nxt, 30'b0});
  assign xv       = 32'(ucsj_pkg::rnd_asr(66'(xp_r), 30));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r  <= s0;
      a1_r  <= s1;
      a2_r  <= s2;
      pv_r  <= dts * v;
      pw_r  <= dts * w;
      pth_r <= 64'(s2) * ucsj_pkg::INV_TWO_PI_Q32;

      side2_r.s0 <= a0_r;
      side2_r.s1 <= a1_r;
      side2_r.s2 <= a2_r;
      side2_r.dv <= ucsj_pkg::sat32(ucsj_pkg::rnd_asr(66'(pv_r), FRAC_BITS));
      side2_r.dw <= ucsj_pkg::sat32(ucsj_pkg::rnd_asr(66'(pw_r), FRAC_BITS));
      xp_r       <= 64'(red) * ucsj_pkg::HALF_PI_Q30;
      quad2_r    <= quad_nxt;

      side3_r <= side2_r;
      x_r     <= xv;
      xx_r    <= 64'(xv) * 64'(xv);
      quad3_r <= quad2_r;
    end
  end

  assign out_vld = vld_r[2];
  assign side    = side3_r;
  assign x       = x_r;
  assign xx      = xx_r;
  assign quad    = quad3_r;

endmodule

// ===== hdl/ucsj_sincos.sv =====
// ----------------------------------------------------------------------------
// ucsj_sincos
// pipelined horner series for sine and cosine with quadrant fold
// ----------------------------------------------------------------------------
module ucsj_sincos (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  ucsj_pkg::side_t    side_in,
  input  ucsj_pkg::q_t       x,
  input  logic signed [63:0] xx,
  input  logic [1:0]         quad,
  output logic               out_vld,
  output ucsj_pkg::side_t    side_out,
  output ucsj_pkg::q_t       sn,
  output ucsj_pkg::q_t       cs
);

  localparam int NSTG = 9;

  typedef struct packed {
    ucsj_pkg::side_t side;
    ucsj_pkg::q_t    x;
    logic [29:0]     x2;
    logic [1:0]      quad;
    logic [30:0]     ts;
    logic [30:0]     tc;
    logic [63:0]     pa;
    logic [63:0]     pb;
    ucsj_pkg::q_t    sn;
    ucsj_pkg::q_t    cs;
  } sc_t;

  sc_t            stg_r [NSTG];
  sc_t            stg_nxt [NSTG];
  logic [NSTG-1:0] vld_r;

  ucsj_pkg::q_t s_v;
  ucsj_pkg::q_t c_v;
  logic [30:0]  c_u;

  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      stg_nxt[i] = stg_r[(i == 0) ? 0 : i - 1];
    end

    stg_nxt[0].side = side_in;
    stg_nxt[0].x    = x;
    stg_nxt[0].quad = quad;
    stg_nxt[0].x2   = xx[59:30];
    stg_nxt[0].ts   = ucsj_pkg::Q30_ONE
                      - 31'(ucsj_pkg::div_k(xx[59:30], ucsj_pkg::K_S1, ucsj_pkg::M_S1));
    stg_nxt[0].tc   = ucsj_pkg::Q30_ONE
                      - 31'(ucsj_pkg::div_k(xx[59:30], ucsj_pkg::K_C1, ucsj_pkg::M_C1));

    // product stages
    for (int i = 1; i < 7; i += 2) begin
      stg_nxt[i].pa = 64'(stg_r[i-1].x2) * 64'(stg_r[i-1].ts);
      stg_nxt[i].pb = 64'(stg_r[i-1].x2) * 64'(stg_r[i-1].tc);
    end

    stg_nxt[2].ts = ucsj_pkg::Q30_ONE
                    - 31'(ucsj_pkg::div_k(stg_r[1].pa[59:30], ucsj_pkg::K_S2, ucsj_pkg::M_S2));
    stg_nxt[2].tc = ucsj_pkg::Q30_ONE
                    - 31'(ucsj_pkg::div_k(stg_r[1].pb[59:30], ucsj_pkg::K_C2, ucsj_pkg::M_C2));
    stg_nxt[4].ts = ucsj_pkg::Q30_ONE
                    - 31'(ucsj_pkg::div_k(stg_r[3].pa[59:30], ucsj_pkg::K_S3, ucsj_pkg::M_S3));
    stg_nxt[4].tc = ucsj_pkg::Q30_ONE
                    - 31'(ucsj_pkg::div_k(stg_r[3].pb[59:30], ucsj_pkg::K_C3, ucsj_pkg::M_C3));
    stg_nxt[6].ts = ucsj_pkg::Q30_ONE
                    - 31'(ucsj_pkg::div_k(stg_r[5].pa[59:30], ucsj_pkg::K_S4, ucsj_pkg::M_S4));
    stg_nxt[6].tc = ucsj_pkg::Q30_ONE
                    - 31'(ucsj_pkg::div_k(stg_r[5].pb[59:30], ucsj_pkg::K_C4, ucsj_pkg::M_C4));

    // sine closes with x * t, signed product taken modulo 2^64
    stg_nxt[7].pa = {{32{stg_r[6].x[31]}}, stg_r[6].x} * 64'(stg_r[6].ts);
    stg_nxt[7].pb = 64'(stg_r[6].x2) * 64'(stg_r[6].tc);

    s_v = $signed(stg_r[7].pa[61:30]);
    c_u = ucsj_pkg::Q30_ONE - 31'(stg_r[7].pb[59:31]);
    c_v = $signed({1'b0, c_u});
    case (stg_r[7].quad)
      2'd0: begin
        stg_nxt[8].sn = s_v;
        stg_nxt[8].cs = c_v;
      end
      2'd1: begin
        stg_nxt[8].sn = c_v;
        stg_nxt[8].cs = -s_v;
      end
      2'd2: begin
        stg_nxt[8].sn = -s_v;
        stg_nxt[8].cs = -c_v;
      end
      default: begin
        stg_nxt[8].sn = -c_v;
        stg_nxt[8].cs = s_v;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NSTG; i++) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign out_vld  = vld_r[NSTG-1];
  assign side_out = stg_r[NSTG-1].side;
  assign sn       = stg_r[NSTG-1].sn;
  assign cs       = stg_r[NSTG-1].cs;

endmodule

// ===== hdl/ucsj_back.sv =====
// ----------------------------------------------------------------------------
// ucsj_back
// forms the next state and jacobian rows for the selected model
// ----------------------------------------------------------------------------
module ucsj_back #(
  parameter int FRAC_BITS = ucsj_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  ucsj_pkg::side_t        side,
  input  ucsj_pkg::q_t           sn,
  input  ucsj_pkg::q_t           cs,
  input  logic [15:0]            step_time,
  input  logic                   model_sel,
  output logic                   out_vld,
  output ucsj_pkg::row_t [2:0]   rows
);

  logic [1:0]           vld_r;
  ucsj_pkg::side_t      side_r;
  logic signed [63:0]   p_t0_r, p_t1_r, p_a0_r, p_a1_r;
  logic signed [63:0]   p_e0_r, p_e1_r, p_d0_r, p_d1_r;
  ucsj_pkg::row_t [2:0] rows_r;
  ucsj_pkg::row_t [2:0] rows_nxt;

  logic signed [63:0] dext;
  logic signed [65:0] t0, t1, a0, a1, e0, e1, d0, d1;
  logic signed [65:0] d66;
  ucsj_pkg::q_t       one_q;
  ucsj_pkg::q_t       dq;

  assign dext  = $signed(64'(step_time));
  assign d66   = $signed(66'(step_time));
  assign dq    = $signed({16'b0, step_time});
  assign one_q = 32'(1 << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side;
      p_t0_r <= 64'(side.dv) * 64'(cs);
      p_t1_r <= 64'(side.dv) * 64'(sn);
      p_a0_r <= dext * 64'(cs);
      p_a1_r <= dext * 64'(sn);
      p_e1_r <= 64'(side.dw) * 64'(side.s1);
      p_e0_r <= 64'(side.dw) * 64'(side.s0);
      p_d1_r <= dext * 64'(side.s1);
      p_d0_r <= dext * 64'(side.s0);
      rows_r <= rows_nxt;
    end
  end

  always_comb begin
    t0 = ucsj_pkg::rnd_asr(66'(p_t0_r), 30);
    t1 = ucsj_pkg::rnd_asr(66'(p_t1_r), 30);
    a0 = ucsj_pkg::rnd_asr(66'(p_a0_r), 30);
    a1 = ucsj_pkg::rnd_asr(66'(p_a1_r), 30);
    e0 = ucsj_pkg::rnd_asr(66'(p_e0_r), FRAC_BITS);
    e1 = ucsj_pkg::rnd_asr(66'(p_e1_r), FRAC_BITS);
    d0 = ucsj_pkg::rnd_asr(66'(p_d0_r), FRAC_BITS);
    d1 = ucsj_pkg::rnd_asr(66'(p_d1_r), FRAC_BITS);
    rows_nxt = '0;
    rows_nxt[0].dstate0 = one_q;
    rows_nxt[1].dstate1 = one_q;
    rows_nxt[2].dstate2 = one_q;
    if (model_sel == ucsj_pkg::MODEL_UNICYCLE) begin
      rows_nxt[0].next_value = ucsj_pkg::sat32(66'(side_r.s0) + t0);
      rows_nxt[1].next_value = ucsj_pkg::sat32(66'(side_r.s1) + t1);
      rows_nxt[2].next_value = ucsj_pkg::sat32(66'(side_r.s2) + 66'(side_r.dw));
      rows_nxt[0].dstate2    = ucsj_pkg::sat32(-t1);
      rows_nxt[1].dstate2    = ucsj_pkg::sat32(t0);
      rows_nxt[0].dctrl0     = ucsj_pkg::sat32(a0);
      rows_nxt[1].dctrl0     = ucsj_pkg::sat32(a1);
      rows_nxt[2].dctrl1     = dq;
    end else begin
      rows_nxt[0].next_value = ucsj_pkg::sat32(66'(side_r.s0) + e1 - 66'(side_r.dv));
      rows_nxt[1].next_value = ucsj_pkg::sat32(66'(side_r.s1) - e0);
      rows_nxt[2].next_value = ucsj_pkg::sat32(66'(side_r.s2) - 66'(side_r.dw));
      rows_nxt[0].dstate1    = side_r.dw;
      rows_nxt[1].dstate0    = ucsj_pkg::sat32(-66'(side_r.dw));
      rows_nxt[0].dctrl0     = -dq;
      rows_nxt[0].dctrl1     = ucsj_pkg::sat32(d1);
      rows_nxt[1].dctrl1     = ucsj_pkg::sat32(-d0);
      rows_nxt[2].dctrl1     = ucsj_pkg::sat32(-d66);
    end
  end

  assign out_vld = vld_r[1];
  assign rows    = rows_r;

endmodule

// ===== hdl/ucsj_rowser.sv =====
// ----------------------------------------------------------------------------
// ucsj_rowser
// output buffer that sends the three rows of one item in order
// ----------------------------------------------------------------------------
module ucsj_rowser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  ucsj_pkg::row_t [2:0] rows,
  output logic                 take,
  output logic                 full,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [1:0]           row_index,
  output ucsj_pkg::row_t       row,
  output logic                 last_row
);

  ucsj_pkg::row_t [2:0] rows_r;
  logic [1:0]           cnt_r;
  logic                 full_r;

  assign take = !full_r || (out_ready && cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (full_r && out_ready) begin
        if (cnt_r == 2'd2) begin
          full_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 2'd1;
        end
      end
      if (take && in_vld) begin
        full_r <= 1'b1;
        cnt_r  <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_vld) begin
      rows_r <= rows;
    end
  end

  always_comb begin
    case (cnt_r)
      2'd0:    row = rows_r[0];
      2'd1:    row = rows_r[1];
      default: row = rows_r[2];
    endcase
  end

  assign full      = full_r;
  assign out_valid = full_r;
  assign row_index = cnt_r;
  assign last_row  = (cnt_r == 2'd2);

endmodule

// ===== hdl/unicycle_step_with_jacobians_unit.sv =====
// ----------------------------------------------------------------------------
// unicycle_step_with_jacobians_unit
// euler step of the unicycle or error-tracking model with its jacobians
// ----------------------------------------------------------------------------
// Each accepted state/control transaction produces three result rows (row 0,
// 1, 2, the last flagged), sent one at a time over the single result port;
// inputs enter a 14-stage pipeline that can take one per cycle unless a
// busy output buffer stalls it, so new inputs are accepted while earlier
// rows are still being sent. Sine and cosine come from a pipelined Horner
// series; all results are saturated Q16.16 by default.
module unicycle_step_with_jacobians_unit #(
  parameter int FRAC_BITS = ucsj_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_heading,
  input  logic signed [31:0] in_lin_speed,
  input  logic signed [31:0] in_ang_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_next_value,
  output logic signed [31:0] out_dstate_col0,
  output logic signed [31:0] out_dstate_col1,
  output logic signed [31:0] out_dstate_col2,
  output logic signed [31:0] out_dctrl_col0,
  output logic signed [31:0] out_dctrl_col1,
  output logic               out_last_row,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [15:0] step_time_r;
  logic        model_sel_r;

  logic                 en;
  logic                 fr_vld, sc_vld, bk_vld;
  ucsj_pkg::side_t      fr_side, sc_side;
  ucsj_pkg::q_t         fr_x, sc_sn, sc_cs;
  logic signed [63:0]   fr_xx;
  logic [1:0]           fr_quad;
  ucsj_pkg::row_t [2:0] bk_rows;
  ucsj_pkg::row_t       o_row;
  logic                 ser_take, ser_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= ucsj_pkg::STEP_TIME_RST;
      model_sel_r <= ucsj_pkg::MODEL_UNICYCLE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ucsj_pkg::CFG_STEP_TIME: step_time_r <= cfg_data;
        ucsj_pkg::CFG_MODEL_SEL: model_sel_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the last stage is held by a busy output buffer
  assign en       = !bk_vld || ser_take;
  assign in_ready = en;

  ucsj_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_valid),
    .s0        (in_pos_x),
    .s1        (in_pos_y),
    .s2        (in_heading),
    .v         (in_lin_speed),
    .w         (in_ang_speed),
    .step_time (step_time_r),
    .out_vld   (fr_vld),
    .side      (fr_side),
    .x         (fr_x),
    .xx        (fr_xx),
    .quad      (fr_quad)
  );

  ucsj_sincos u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .side_in  (fr_side),
    .x        (fr_x),
    .xx       (fr_xx),
    .quad     (fr_quad),
    .out_vld  (sc_vld),
    .side_out (sc_side),
    .sn       (sc_sn),
    .cs       (sc_cs)
  );

  ucsj_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (sc_vld),
    .side      (sc_side),
    .sn        (sc_sn),
    .cs        (sc_cs),
    .step_time (step_time_r),
    .model_sel (model_sel_r),
    .out_vld   (bk_vld),
    .rows      (bk_rows)
  );

  ucsj_rowser u_rowser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (bk_vld),
    .rows      (bk_rows),
    .take      (ser_take),
    .full      (ser_full),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .row_index (out_row_index),
    .row       (o_row),
    .last_row  (out_last_row)
  );

  assign out_next_value  = o_row.next_value;
  assign out_dstate_col0 = o_row.dstate0;
  assign out_dstate_col1 = o_row.dstate1;
  assign out_dstate_col2 = o_row.dstate2;
  assign out_dctrl_col0  = o_row.dctrl0;
  assign out_dctrl_col1  = o_row.dctrl1;

  // rows of one item follow each other without gaps in index
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_row) |=>
      (out_valid && out_row_index == $past(out_row_index) + 2'd1))
    else $error("result rows out of order");

  // an empty output buffer never holds back the pipeline
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !ser_full |-> in_ready)
    else $error("input stalled with empty output buffer");

  // the heading row always carries a unit diagonal
  a_row2_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row_index == 2'd2) |->
      (out_dstate_col2 == 32'(1 << FRAC_BITS) && out_dstate_col0 == 32'sd0))
    else $error("heading row jacobian diagonal wrong");

endmodule
